[hdl/tdiff_pkg.sv]
// Shared types, constants and helpers for the dual tracking differentiator.
// No dependencies; tdiff_lane and the top level refer to this package by scoped names.
package tdiff_pkg;

  localparam int TD_CHANNELS = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPEED  = 2'd0;
  localparam logic [1:0] CFG_FILTER = 2'd1;
  localparam logic [1:0] CFG_SAMPLE = 2'd2;

  // Step counts of the iterative units.
  localparam logic [6:0] QDIV_STEPS = 7'd80;
  localparam logic [6:0] RDIV_STEPS = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  typedef struct packed {
    logic [31:0] speed;   // r, Q16.16
    logic [31:0] filt;    // h, Q0.32
    logic [31:0] samp;    // dt, Q0.32
  } cfg_t;

  typedef struct packed {
    logic start;
    logic first;
  } lane_ctl_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] rate;
  } lane_sts_t;

  typedef enum logic {
    TOP_IDLE,
    TOP_RUN
  } top_state_t;

  typedef enum logic [3:0] {
    LS_IDLE,
    LS_D,
    LS_D0,
    LS_Y,
    LS_DD,
    LS_RY,
    LS_SQRT,
    LS_QDIV,
    LS_PREP,
    LS_NORM,
    LS_RDIV,
    LS_RM,
    LS_FD,
    LS_XD,
    LS_DONE
  } lane_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

[hdl/tdiff_if.sv]
// Request and result channel interfaces for the dual tracking differentiator.
// Depends on nothing; used by the top level.
interface tdiff_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] yaw_angle;
  modport source (output valid, output pitch_angle, output yaw_angle, input ready);
  modport sink (input valid, input pitch_angle, input yaw_angle, output ready);
endinterface

interface tdiff_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pitch_rate;
  logic signed [31:0] yaw_rate;
  modport source (output valid, output pitch_rate, output yaw_rate, input ready);
  modport sink (input valid, input pitch_rate, input yaw_rate, output ready);
endinterface

[hdl/tdiff_mul.sv]
// Iterative 64x64 unsigned multiplier built from four 32x32 partial products.
// No package dependencies; used by each tracking lane.
module tdiff_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   op_a,
  input  logic [63:0]   op_b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    pb = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp = pa * pb;
    case (cnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[hdl/tdiff_lane.sv]
// One tracking differentiator lane: fhan law with iterative square root and divider.
// Depends on tdiff_pkg and tdiff_mul.
module tdiff_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tdiff_pkg::cfg_t       cfg,
  input  tdiff_pkg::lane_ctl_t  ctl,
  input  logic signed [31:0]    sample,
  output tdiff_pkg::lane_sts_t  sts
);

  tdiff_pkg::lane_state_t state_r, state_nxt;

  logic signed [31:0] x1_r, x2_r, v_r;
  logic               mw_r;
  logic [47:0]        d_r, d0_r, mm_r, dd_r;
  logic signed [63:0] y_r, a_r;
  logic [63:0]        ay_r;
  logic [63:0]        rad_r;
  logic [63:0]        sq_n_r, sq_res_r, sq_bit_r;
  logic [79:0]        dvd_r;
  logic [31:0]        dvs_r, rem_r;
  logic [63:0]        quo_r;
  logic [6:0]         cnt_r;
  logic [48:0]        fmag_r;
  logic               fneg_r;

  logic               mul_start, mul_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod;

  logic               is_mul;
  logic [31:0]        x2_mag;
  logic signed [32:0] dif;
  logic signed [63:0] x2q, y_calc, t_y, half, diff, a_mag_s;
  logic [63:0]        ay_calc, a_mag, sq_sum;
  logic [32:0]        div_sh;
  logic               div_ge;
  logic [63:0]        t_fd, t_xd;

  tdiff_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    x2_mag  = x2_r[31] ? 32'(-x2_r) : x2_r;
    x2q     = {{32{x2_r[31]}}, x2_r} <<< 16;
    dif     = 33'(x1_r) - 33'(v_r);
    t_y     = $signed(prod[79:16]);
    y_calc  = ({{31{dif[32]}}, dif} <<< 16) + (x2_r[31] ? -t_y : t_y);
    ay_calc = y_calc[63] ? 64'(-y_calc) : 64'(y_calc);
    diff    = $signed({14'd0, sq_res_r[31:0], 18'd0}) - $signed({16'd0, d_r});
    half    = (diff + (diff[63] ? 64'sd1 : 64'sd0)) >>> 1;
    a_mag_s = a_r[63] ? -a_r : a_r;
    a_mag   = 64'(a_mag_s);
    sq_sum  = sq_res_r + sq_bit_r;
    div_sh  = {rem_r, dvd_r[79]};
    div_ge  = div_sh >= {1'b0, dvs_r};
    t_fd    = prod[111:48];
    t_xd    = prod[95:32];
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tdiff_pkg::LS_D:  begin mul_a = 64'(cfg.speed); mul_b = 64'(cfg.filt); end
      tdiff_pkg::LS_D0: begin mul_a = 64'(d_r);       mul_b = 64'(cfg.filt); end
      tdiff_pkg::LS_Y:  begin mul_a = 64'(x2_mag);    mul_b = 64'(cfg.filt); end
      tdiff_pkg::LS_DD: begin mul_a = 64'(d_r);       mul_b = 64'(d_r);      end
      tdiff_pkg::LS_RY: begin mul_a = 64'(cfg.speed); mul_b = ay_r;          end
      tdiff_pkg::LS_RM: begin mul_a = 64'(cfg.speed); mul_b = 64'(quo_r[32:0]); end
      tdiff_pkg::LS_FD: begin mul_a = 64'(fmag_r);    mul_b = 64'(cfg.samp); end
      tdiff_pkg::LS_XD: begin mul_a = 64'(x2_mag);    mul_b = 64'(cfg.samp); end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdiff_pkg::LS_IDLE: if (ctl.start) state_nxt = tdiff_pkg::LS_D;
      tdiff_pkg::LS_D:    if (mul_done) state_nxt = tdiff_pkg::LS_D0;
      tdiff_pkg::LS_D0:   if (mul_done) state_nxt = tdiff_pkg::LS_Y;
      tdiff_pkg::LS_Y: begin
        if (mul_done) begin
          if (ay_calc > {16'd0, d0_r}) state_nxt = tdiff_pkg::LS_DD;
          else if (cfg.filt != '0)     state_nxt = tdiff_pkg::LS_QDIV;
          else                         state_nxt = tdiff_pkg::LS_PREP;
        end
      end
      tdiff_pkg::LS_DD:   if (mul_done) state_nxt = tdiff_pkg::LS_RY;
      tdiff_pkg::LS_RY:   if (mul_done) state_nxt = tdiff_pkg::LS_SQRT;
      tdiff_pkg::LS_SQRT: if (cnt_r == '0) state_nxt = tdiff_pkg::LS_PREP;
      tdiff_pkg::LS_QDIV: if (cnt_r == '0) state_nxt = tdiff_pkg::LS_PREP;
      tdiff_pkg::LS_PREP: begin
        if (d_r != '0 && a_r != '0) state_nxt = tdiff_pkg::LS_NORM;
        else                        state_nxt = tdiff_pkg::LS_FD;
      end
      tdiff_pkg::LS_NORM: if (dd_r[47:32] == '0) state_nxt = tdiff_pkg::LS_RDIV;
      tdiff_pkg::LS_RDIV: if (cnt_r == '0) state_nxt = tdiff_pkg::LS_RM;
      tdiff_pkg::LS_RM:   if (mul_done) state_nxt = tdiff_pkg::LS_FD;
      tdiff_pkg::LS_FD:   if (mul_done) state_nxt = tdiff_pkg::LS_XD;
      tdiff_pkg::LS_XD:   if (mul_done) state_nxt = tdiff_pkg::LS_DONE;
      tdiff_pkg::LS_DONE: state_nxt = tdiff_pkg::LS_IDLE;
      default:            state_nxt = tdiff_pkg::LS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    unique case (state_r)
      tdiff_pkg::LS_D, tdiff_pkg::LS_D0, tdiff_pkg::LS_Y, tdiff_pkg::LS_DD,
      tdiff_pkg::LS_RY, tdiff_pkg::LS_RM, tdiff_pkg::LS_FD, tdiff_pkg::LS_XD:
        is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
    mul_start = is_mul && !mw_r;
    sts.done  = (state_r == tdiff_pkg::LS_DONE);
    sts.rate  = x2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdiff_pkg::LS_IDLE;
      mw_r    <= 1'b0;
      x1_r    <= '0;
      x2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_done)       mw_r <= 1'b0;
      else if (mul_start) mw_r <= 1'b1;

      case (state_r)
        tdiff_pkg::LS_IDLE: begin
          if (ctl.start) begin
            v_r <= sample;
            if (ctl.first) begin
              x1_r <= sample;
              x2_r <= '0;
            end
          end
        end
        tdiff_pkg::LS_D:  if (mul_done) d_r  <= prod[63:16];
        tdiff_pkg::LS_D0: if (mul_done) d0_r <= prod[79:32];
        tdiff_pkg::LS_Y: begin
          if (mul_done) begin
            y_r   <= y_calc;
            ay_r  <= ay_calc;
            a_r   <= x2q;
            dvd_r <= {ay_calc[47:0], 32'd0};
            dvs_r <= cfg.filt;
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= tdiff_pkg::QDIV_STEPS;
          end
        end
        tdiff_pkg::LS_DD: if (mul_done) rad_r <= prod[99:36];
        tdiff_pkg::LS_RY: begin
          if (mul_done) begin
            sq_n_r   <= rad_r + prod[80:17];
            sq_res_r <= '0;
            sq_bit_r <= 64'd1 << 62;
            cnt_r    <= tdiff_pkg::SQRT_STEPS;
          end
        end
        tdiff_pkg::LS_SQRT: begin
          if (cnt_r != '0) begin
            if (sq_n_r >= sq_sum) begin
              sq_n_r   <= sq_n_r - sq_sum;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
            cnt_r    <= cnt_r - 7'd1;
          end else begin
            a_r <= (y_r > 0) ? x2q + half : x2q - half;
          end
        end
        tdiff_pkg::LS_QDIV, tdiff_pkg::LS_RDIV: begin
          if (cnt_r != '0) begin
            rem_r <= div_ge ? 32'(div_sh - {1'b0, dvs_r}) : div_sh[31:0];
            quo_r <= {quo_r[62:0], div_ge};
            dvd_r <= dvd_r << 1;
            cnt_r <= cnt_r - 7'd1;
          end else if (state_r == tdiff_pkg::LS_QDIV) begin
            a_r <= y_r[63] ? x2q - $signed(quo_r) : x2q + $signed(quo_r);
          end
        end
        tdiff_pkg::LS_PREP: begin
          mm_r   <= (a_mag < 64'(d_r)) ? a_mag[47:0] : d_r;
          dd_r   <= d_r;
          fmag_r <= '0;
          fneg_r <= 1'b0;
        end
        tdiff_pkg::LS_NORM: begin
          if (dd_r[47:32] != '0) begin
            dd_r <= dd_r >> 1;
            mm_r <= mm_r >> 1;
          end else begin
            dvd_r <= {mm_r[31:0], 48'd0};
            dvs_r <= dd_r[31:0];
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= tdiff_pkg::RDIV_STEPS;
          end
        end
        tdiff_pkg::LS_RM: begin
          if (mul_done) begin
            fmag_r <= prod[64:16];
            fneg_r <= !a_r[63];   // a is nonzero here, so a > 0 drives negative
          end
        end
        tdiff_pkg::LS_FD: begin
          if (mul_done) begin
            x2_r <= tdiff_pkg::sat32({{32{x2_r[31]}}, x2_r} +
                                     (fneg_r ? -$signed(t_fd) : $signed(t_fd)));
          end
        end
        tdiff_pkg::LS_XD: begin
          if (mul_done) begin
            x1_r <= tdiff_pkg::sat32({{32{x1_r[31]}}, x1_r} +
                                     (x2_r[31] ? -$signed(t_xd) : $signed(t_xd)));
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/dual_tracking_differentiator.sv]
// Top level of the dual tracking differentiator: configuration, lanes, merge.
// Depends on tdiff_pkg, tdiff_if and tdiff_lane.
//
//   Channel   Direction  Handshake        Payload
//   in_ch     sink       valid / ready    pitch_angle, yaw_angle (signed Q16.16)
//   out_ch    source     valid / ready    pitch_rate, yaw_rate (signed Q16.16)
//   cfg_*     sink       cfg_we only      cfg_index selects r, h or dt; cfg_wdata
//
// A result becomes valid once both lanes have finished and the output register
// has room, and the next request can be taken in the same cycle that it becomes
// valid. Both lanes run in parallel and the slower lane sets when it is ready:
// five to eight multiplies (start, four partial products, done), the square root
// or, when h is nonzero, the divide by h, and, when there is drive, a
// normalization of at most 16 shifts and the ratio divide. Reset is synchronous
// and active low; it restores the default configuration and marks the next
// request as the first one. The input is ready whenever the request sequencer is
// idle, so a new request can be taken while a finished result still sits in the
// output register; a result that finds the register full stalls the input until
// out_ch.ready frees it.
module dual_tracking_differentiator (
  input  logic           clk,
  input  logic           rst_n,
  tdiff_in_if.sink       in_ch,
  tdiff_out_if.source    out_ch,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  localparam int NCH = tdiff_pkg::TD_CHANNELS;

  tdiff_pkg::top_state_t state_r, state_nxt;
  tdiff_pkg::cfg_t       cfg_r;

  logic                  first_r;
  logic [NCH-1:0]        done_r;
  logic                  out_valid_r;
  logic signed [31:0]    out_rate_r [NCH];

  logic                  in_acc;
  logic                  all_done;
  logic                  load_out;
  logic                  in_ready;

  tdiff_pkg::lane_ctl_t  lane_ctl;
  tdiff_pkg::lane_sts_t  lane_sts [NCH];
  logic signed [31:0]    lane_v   [NCH];

  // Lane 0 tracks pitch and lane 1 tracks yaw.
  assign lane_v[0] = in_ch.pitch_angle;
  assign lane_v[1] = in_ch.yaw_angle;

  assign in_acc         = in_ch.valid && in_ready;
  assign all_done       = &done_r;
  assign lane_ctl.start = in_acc;
  assign lane_ctl.first = first_r;

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    tdiff_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cfg    (cfg_r),
      .ctl    (lane_ctl),
      .sample (lane_v[g]),
      .sts    (lane_sts[g])
    );
  end

  // Next state: a request runs until every lane has finished and the
  // merged result has found room in the output register.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdiff_pkg::TOP_IDLE: if (in_acc) state_nxt = tdiff_pkg::TOP_RUN;
      tdiff_pkg::TOP_RUN:  if (load_out) state_nxt = tdiff_pkg::TOP_IDLE;
      default:             state_nxt = tdiff_pkg::TOP_IDLE;
    endcase
  end

  // Outputs of the request sequencer.
  always_comb begin
    unique case (state_r)
      tdiff_pkg::TOP_IDLE: begin
        in_ready = 1'b1;
        load_out = 1'b0;
      end
      tdiff_pkg::TOP_RUN: begin
        in_ready = 1'b0;
        load_out = all_done && (!out_valid_r || out_ch.ready);
      end
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdiff_pkg::TOP_IDLE;
      first_r     <= 1'b1;
      done_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_r.speed <= 32'd6553600;
      cfg_r.filt  <= 32'd42949673;
      cfg_r.samp  <= 32'd4294967;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          tdiff_pkg::CFG_SPEED:  cfg_r.speed <= cfg_wdata;
          tdiff_pkg::CFG_FILTER: cfg_r.filt  <= cfg_wdata;
          tdiff_pkg::CFG_SAMPLE: cfg_r.samp  <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_acc) begin
        first_r <= 1'b0;
        done_r  <= '0;
      end else begin
        for (int i = 0; i < NCH; i++) begin
          if (lane_sts[i].done) done_r[i] <= 1'b1;
        end
      end

      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // The merge stage: once all lanes are done, their rates form one result.
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < NCH; i++) begin
        out_rate_r[i] <= lane_sts[i].rate;
      end
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pitch_rate = out_rate_r[0];
  assign out_ch.yaw_rate   = out_rate_r[1];

endmodule
